### rtl/bncd_pkg.sv
// Package for the birth number check and decode block.
// Holds the accumulator state type and the fixed constants; no dependencies.
package bncd_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned PairW   = 7;
    localparam int unsigned DigitW  = 4;
    localparam int unsigned YearW   = 12;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned AgeW    = 9;
    localparam int unsigned OutDataW = 40;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TODAY_YEAR  = 2'd0;
    localparam logic [1:0] REG_TODAY_MONTH = 2'd1;
    localparam logic [1:0] REG_TODAY_DAY   = 2'd2;

    localparam logic [CharW-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CharW-1:0]  CHAR_NINE  = 8'd57;
    localparam logic [3:0]        NUM_CHARS  = 4'd10;
    localparam logic [3:0]        CNT_SAT    = 4'd11;
    localparam logic [3:0]        CHECK_POS  = 4'd9;
    localparam logic [4:0]        MODULUS    = 5'd11;
    localparam logic [3:0]        REM_TEN    = 4'd10;
    localparam logic [PairW-1:0]  MONTH_MAX  = 7'd12;
    localparam logic [PairW-1:0]  MONTH_OFS  = 7'd50;
    localparam logic [PairW-1:0]  FEMALE_MIN = 7'd50;
    localparam logic [PairW-1:0]  CENTURY_SPLIT = 7'd54;
    localparam logic [YearW-1:0]  BASE_1900  = 12'd1900;
    localparam logic [YearW-1:0]  BASE_2000  = 12'd2000;

    localparam logic [YearW-1:0]  RST_YEAR   = 12'd2026;
    localparam logic [MonthW-1:0] RST_MONTH  = 4'd1;
    localparam logic [DayW-1:0]   RST_DAY    = 5'd1;

    localparam logic signed [13:0] AGE_MAX = 14'sd255;
    localparam logic signed [13:0] AGE_MIN = -14'sd256;

    typedef struct packed {
        logic [DigitW-1:0] rem;
        logic [3:0]        cnt;
        logic              bad;
        logic [PairW-1:0]  year;
        logic [PairW-1:0]  month;
        logic [PairW-1:0]  day;
        logic [DigitW-1:0] chk;
    } t_acc;

endpackage

### rtl/birth_number_check_decode.sv
// Birth number check and decode: checks a ten-digit birth number for its
// mod 11 check digit and decodes date of birth, sex and age. Uses bncd_pkg.
//
// Channel   Dir  Signals                       Content
// s_axis    in   tdata[7:0], tlast             one ASCII character, tlast on the final one
// m_axis    out  tdata[39:0], tuser[0]         decoded result, tuser = valid_res
// cfg       in   i_cfg_we, i_cfg_index[1:0],   today_year, today_month, today_day
//                i_cfg_wdata[11:0]
//
// One character is accepted per cycle. The running state is updated on
// every accepted character; the final character copies it into a snapshot
// register and clears it, and once the output register is free the snapshot
// is turned into the result held there. Stalls on m_axis back up through
// the output and snapshot registers to s_axis_tready. Reset is synchronous,
// active low.
module birth_number_check_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [6:0] birth_day, [13:7] birth_month,
                                        // [25:14] birth_year, [26] female,
                                        // [35:27] age_years, [39:36] zero
    output logic        m_axis_tuser,   // valid_res
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_wdata
);

    logic [bncd_pkg::YearW-1:0]  r_today_year;
    logic [bncd_pkg::MonthW-1:0] r_today_month;
    logic [bncd_pkg::DayW-1:0]   r_today_day;

    bncd_pkg::t_acc r_acc, n_acc;
    bncd_pkg::t_acc r_snap;
    logic           r_snap_valid;

    logic                         r_out_valid;
    logic                         r_out_ok;
    logic [bncd_pkg::PairW-1:0]   r_out_day;
    logic [bncd_pkg::PairW-1:0]   r_out_month;
    logic [bncd_pkg::YearW-1:0]   r_out_year;
    logic                         r_out_female;
    logic [bncd_pkg::AgeW-1:0]    r_out_age;

    logic out_free, snap_move, in_fire;
    logic is_digit;
    logic [bncd_pkg::DigitW-1:0] digit;
    logic [4:0] rem_diff;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign snap_move     = r_snap_valid && out_free;
    assign s_axis_tready = !r_snap_valid || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Character step. Since 10 is -1 modulo 11, the new remainder is the
    // digit less the old remainder, brought back into range.
    always_comb begin
        is_digit = s_axis_tdata inside {[bncd_pkg::CHAR_ZERO:bncd_pkg::CHAR_NINE]};
        digit    = 4'(s_axis_tdata - bncd_pkg::CHAR_ZERO);
        rem_diff = {1'b0, digit} - {1'b0, r_acc.rem};
        if (digit < r_acc.rem) begin
            rem_diff = rem_diff + bncd_pkg::MODULUS;
        end
        n_acc = r_acc;
        if (!is_digit) begin
            n_acc.bad = 1'b1;
        end else begin
            if (r_acc.cnt < bncd_pkg::CHECK_POS) begin
                n_acc.rem = rem_diff[3:0];
            end
            case (r_acc.cnt)
                4'd0, 4'd1: n_acc.year  = 7'(r_acc.year * 7'd10 + {3'b0, digit});
                4'd2, 4'd3: n_acc.month = 7'(r_acc.month * 7'd10 + {3'b0, digit});
                4'd4, 4'd5: n_acc.day   = 7'(r_acc.day * 7'd10 + {3'b0, digit});
                bncd_pkg::CHECK_POS: n_acc.chk = digit;
                default: ;
            endcase
        end
        if (r_acc.cnt < bncd_pkg::CNT_SAT) begin
            n_acc.cnt = r_acc.cnt + 4'd1;
        end
    end

    // Decode of the snapshot.
    logic                       ok;
    logic [bncd_pkg::PairW-1:0] month_adj;
    logic [bncd_pkg::YearW-1:0] year_full;
    logic signed [13:0]         age_raw;
    logic signed [7:0]          month_s;
    logic                       age_dec;
    logic [bncd_pkg::AgeW-1:0]  age_sat;

    always_comb begin
        ok = (r_snap.cnt == bncd_pkg::NUM_CHARS) && !r_snap.bad &&
             ((r_snap.chk == r_snap.rem) ||
              (r_snap.rem == bncd_pkg::REM_TEN && r_snap.chk == 4'd0));
        month_adj = r_snap.month;
        if (r_snap.month > bncd_pkg::MONTH_MAX) begin
            month_adj = r_snap.month - bncd_pkg::MONTH_OFS;
        end
        month_s   = {month_adj[6], month_adj};
        year_full = {5'b0, r_snap.year} +
                    ((r_snap.year >= bncd_pkg::CENTURY_SPLIT) ?
                     bncd_pkg::BASE_1900 : bncd_pkg::BASE_2000);
        age_dec = ($signed({4'b0, r_today_month}) < month_s) ||
                  (($signed({4'b0, r_today_month}) == month_s) &&
                   ({2'b0, r_today_day} < r_snap.day));
        age_raw = $signed({2'b0, r_today_year}) - $signed({2'b0, year_full}) -
                  $signed({13'b0, age_dec});
        if (age_raw > bncd_pkg::AGE_MAX) begin
            age_sat = 9'(bncd_pkg::AGE_MAX);
        end else if (age_raw < bncd_pkg::AGE_MIN) begin
            age_sat = 9'(bncd_pkg::AGE_MIN);
        end else begin
            age_sat = age_raw[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_today_year  <= bncd_pkg::RST_YEAR;
            r_today_month <= bncd_pkg::RST_MONTH;
            r_today_day   <= bncd_pkg::RST_DAY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bncd_pkg::REG_TODAY_YEAR:  r_today_year  <= i_cfg_wdata;
                bncd_pkg::REG_TODAY_MONTH: r_today_month <= i_cfg_wdata[3:0];
                bncd_pkg::REG_TODAY_DAY:   r_today_day   <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_acc <= s_axis_tlast ? '0 : n_acc;
            end
            if (in_fire && s_axis_tlast) begin
                r_snap_valid <= 1'b1;
            end else if (snap_move) begin
                r_snap_valid <= 1'b0;
            end
            if (snap_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && s_axis_tlast) begin
            r_snap <= n_acc;
        end
        if (snap_move) begin
            r_out_ok     <= ok;
            r_out_day    <= ok ? r_snap.day : '0;
            r_out_month  <= ok ? month_adj : '0;
            r_out_year   <= ok ? year_full : '0;
            r_out_female <= ok && (r_snap.month > bncd_pkg::FEMALE_MIN);
            r_out_age    <= ok ? age_sat : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {4'b0, r_out_age, r_out_female, r_out_year,
                            r_out_month, r_out_day};

endmodule

### tb/tb_birth_number_check_decode.sv
// Self-checking testbench for birth_number_check_decode: streams birth number
// characters with random gaps and stalls, predicts each decoded result and
// compares it with the output stream. Depends on bncd_pkg and the block itself.
module tb_birth_number_check_decode;

    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned CHARS_PER_PHASE = 225;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [bncd_pkg::CharW-1:0] code;
        logic                       fin;
    } t_char_req;

    typedef struct packed {
        logic                              ok;
        logic [bncd_pkg::PairW-1:0]        day;
        logic signed [bncd_pkg::PairW-1:0] month;
        logic [bncd_pkg::YearW-1:0]        year;
        logic                              female;
        logic signed [bncd_pkg::AgeW-1:0]  age;
    } t_decode;

    typedef struct packed {
        logic [bncd_pkg::DigitW-1:0] rem;
        logic [3:0]                  count;
        logic                        nondigit;
        logic [bncd_pkg::PairW-1:0]  yy;
        logic [bncd_pkg::PairW-1:0]  mm;
        logic [bncd_pkg::PairW-1:0]  dd;
        logic [bncd_pkg::DigitW-1:0] chk;
    } t_digit_acc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [11:0] i_cfg_wdata = '0;

    birth_number_check_decode uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    t_char_req  char_queue [$];
    t_decode    due_results [$];
    t_digit_acc acc = '0;

    logic [bncd_pkg::YearW-1:0]  cfg_year  = bncd_pkg::RST_YEAR;
    logic [bncd_pkg::MonthW-1:0] cfg_month = bncd_pkg::RST_MONTH;
    logic [bncd_pkg::DayW-1:0]   cfg_day   = bncd_pkg::RST_DAY;

    logic [7:0]  str_chars [0:15];
    int          str_len = 0;

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_count = 0;

    // Folds one character into the running state; on the final character it
    // produces the decoded record and clears the state.
    function automatic bit decode_char(input logic [7:0] c, input logic fin,
                                       output t_decode res);
        logic [bncd_pkg::DigitW-1:0] d;
        int  year;
        int  month;
        int  age;
        bit  ok;
        res = '0;
        if (!(c inside {[bncd_pkg::CHAR_ZERO:bncd_pkg::CHAR_NINE]})) begin
            acc.nondigit = 1'b1;
        end else begin
            d = bncd_pkg::DigitW'(c - bncd_pkg::CHAR_ZERO);
            if (acc.count < bncd_pkg::CHECK_POS)
                acc.rem = bncd_pkg::DigitW'((int'(acc.rem) * 10 + int'(d)) %
                                            int'(bncd_pkg::MODULUS));
            if (acc.count < 2)
                acc.yy = bncd_pkg::PairW'(int'(acc.yy) * 10 + int'(d));
            else if (acc.count < 4)
                acc.mm = bncd_pkg::PairW'(int'(acc.mm) * 10 + int'(d));
            else if (acc.count < 6)
                acc.dd = bncd_pkg::PairW'(int'(acc.dd) * 10 + int'(d));
            else if (acc.count == bncd_pkg::CHECK_POS)
                acc.chk = d;
        end
        if (acc.count < bncd_pkg::CNT_SAT)
            acc.count = acc.count + 1'b1;
        if (!fin)
            return 1'b0;

        ok = (acc.count == bncd_pkg::NUM_CHARS) && !acc.nondigit &&
             (acc.chk == acc.rem || (acc.rem == bncd_pkg::REM_TEN && acc.chk == 0));
        if (ok) begin
            month = int'(acc.mm);
            if (month > int'(bncd_pkg::MONTH_MAX))
                month = month - int'(bncd_pkg::MONTH_OFS);
            year = int'(acc.yy) + ((acc.yy >= bncd_pkg::CENTURY_SPLIT) ?
                                   int'(bncd_pkg::BASE_1900) :
                                   int'(bncd_pkg::BASE_2000));
            age = int'(cfg_year) - year;
            if (int'(cfg_month) < month)
                age = age - 1;
            else if (int'(cfg_month) == month && int'(cfg_day) < int'(acc.dd))
                age = age - 1;
            if (age > int'(bncd_pkg::AGE_MAX))
                age = int'(bncd_pkg::AGE_MAX);
            if (age < int'(bncd_pkg::AGE_MIN))
                age = int'(bncd_pkg::AGE_MIN);
            res.ok     = 1'b1;
            res.day    = acc.dd;
            res.month  = bncd_pkg::PairW'(month);
            res.year   = bncd_pkg::YearW'(year);
            res.female = (acc.mm > bncd_pkg::FEMALE_MIN);
            res.age    = bncd_pkg::AgeW'(age);
        end
        acc = '0;
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Fills str_chars with a well-formed number whose check digit is correct.
    function automatic void make_number(input int yy, input int mm, input int dd,
                                        input bit want_ten);
        int digs [10];
        int r;
        int tries;
        digs[0] = yy / 10;
        digs[1] = yy % 10;
        digs[2] = mm / 10;
        digs[3] = mm % 10;
        digs[4] = dd / 10;
        digs[5] = dd % 10;
        tries = 0;
        do begin
            for (int i = 6; i < 9; i++)
                digs[i] = $urandom_range(0, 9);
            r = 0;
            for (int i = 0; i < 9; i++)
                r = (r * 10 + digs[i]) % 11;
            tries++;
        end while (want_ten && r != 10 && tries < 1000);
        digs[9] = (r == 10) ? 0 : r;
        for (int i = 0; i < 10; i++)
            str_chars[i] = 8'(48 + digs[i]);
        str_len = 10;
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c inside {[bncd_pkg::CHAR_ZERO:bncd_pkg::CHAR_NINE]});
        return c;
    endfunction

    // Mostly correct numbers with random dates, the rest broken in one way.
    function automatic void gen_string();
        int r;
        int yy;
        int mm;
        int dd;
        r  = $urandom_range(0, 99);
        yy = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0, 1:    mm = $urandom_range(1, 12);
            2:       mm = $urandom_range(51, 62);
            3:       mm = $urandom_range(0, 99);
            default: mm = $urandom_range(48, 55);
        endcase
        dd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        // Birthdays on or next to the configured date exercise the age borrow.
        if ($urandom_range(0, 3) == 0) begin
            mm = int'(cfg_month) + ($urandom_range(0, 1) ? 50 : 0);
            dd = int'(cfg_day) + $urandom_range(0, 2) - 1;
            if (dd < 0)
                dd = 0;
        end
        make_number(yy, mm, dd, $urandom_range(0, 9) == 0);
        if (r < 60) begin
            // well-formed
        end else if (r < 70) begin
            str_chars[9] = 8'(48 + (int'(str_chars[9] - bncd_pkg::CHAR_ZERO) +
                                    $urandom_range(1, 9)) % 10);
        end else if (r < 76) begin
            str_len = $urandom_range(1, 9);
        end else if (r < 82) begin
            str_len = $urandom_range(11, 14);
            for (int i = 10; i < str_len; i++)
                str_chars[i] = ($urandom_range(0, 4) == 0) ? non_digit()
                                                           : 8'(48 + $urandom_range(0, 9));
        end else if (r < 90) begin
            str_chars[$urandom_range(0, 9)] = non_digit();
        end else begin
            str_len = $urandom_range(1, 12);
            for (int i = 0; i < str_len; i++)
                str_chars[i] = 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic push_string(inout int unsigned pushed);
        t_char_req req;
        for (int i = 0; i < str_len; i++) begin
            req.code = str_chars[i];
            req.fin  = (i == str_len - 1);
            char_queue.push_back(req);
        end
        pushed += str_len;
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= 12'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bncd_pkg::REG_TODAY_YEAR:  cfg_year  = bncd_pkg::YearW'(val);
            bncd_pkg::REG_TODAY_MONTH: cfg_month = bncd_pkg::MonthW'(val);
            bncd_pkg::REG_TODAY_DAY:   cfg_day   = bncd_pkg::DayW'(val);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (char_queue.size() != 0 || due_results.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
    endtask

    // Quiet stretches switch idling off on both sides for a while.
    always @(posedge i_clk) begin
        if (quiet_left != 0)
            quiet_left <= quiet_left - 1;
        else if ($urandom_range(0, 299) == 0)
            quiet_left <= $urandom_range(30, 120);
    end

    // Driver: predicts on every accepted request, then offers the next one.
    always @(posedge i_clk) begin : driver_blk
        t_decode   res;
        t_char_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (decode_char(s_axis_tdata, s_axis_tlast, res))
                    due_results.push_back(res);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (char_queue.size() != 0) begin
                    req = char_queue.pop_front();
                    s_axis_tdata  <= req.code;
                    s_axis_tlast  <= req.fin;
                    s_axis_tvalid <= 1'b1;
                    gap_left      <= (quiet_left != 0) ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (quiet_left == 0 && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin : monitor_blk
        t_decode got;
        t_decode want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok     = m_axis_tuser;
            got.day    = m_axis_tdata[6:0];
            got.month  = m_axis_tdata[13:7];
            got.year   = m_axis_tdata[25:14];
            got.female = m_axis_tdata[26];
            got.age    = m_axis_tdata[35:27];
            if (due_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display({"unexpected result: valid=%0d day=%0d month=%0d",
                              " year=%0d female=%0d age=%0d"},
                             got.ok, got.day, got.month, got.year, got.female, got.age);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = due_results.pop_front();
                if (got.ok !== want.ok || got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year || got.female !== want.female ||
                    got.age !== want.age || m_axis_tdata[39:36] !== 4'd0) begin
                    if (mismatch_count < 10) begin
                        $display({"mismatch: expected valid=%0d day=%0d month=%0d",
                                  " year=%0d female=%0d age=%0d"},
                                 want.ok, want.day, want.month, want.year, want.female,
                                 want.age);
                        $display({"          actual   valid=%0d day=%0d month=%0d",
                                  " year=%0d female=%0d age=%0d pad=%h"},
                                 got.ok, got.day, got.month, got.year, got.female, got.age,
                                 m_axis_tdata[39:36]);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request accepted for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned pushed;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_reg(bncd_pkg::REG_TODAY_YEAR, 1900);
                    write_reg(bncd_pkg::REG_TODAY_MONTH, 1);
                    write_reg(bncd_pkg::REG_TODAY_DAY, 1);
                end
                2: begin
                    write_reg(bncd_pkg::REG_TODAY_YEAR, 2099);
                    write_reg(bncd_pkg::REG_TODAY_MONTH, 12);
                    write_reg(bncd_pkg::REG_TODAY_DAY, 31);
                end
                3: begin
                    // Beyond the intended ranges, so the age saturates high.
                    write_reg(bncd_pkg::REG_TODAY_YEAR, 4095);
                    write_reg(bncd_pkg::REG_TODAY_MONTH, 15);
                    write_reg(bncd_pkg::REG_TODAY_DAY, 31);
                end
                4: begin
                    write_reg(bncd_pkg::REG_TODAY_YEAR, 0);
                    write_reg(bncd_pkg::REG_TODAY_MONTH, 0);
                    write_reg(bncd_pkg::REG_TODAY_DAY, 0);
                end
                default: begin
                    write_reg(bncd_pkg::REG_TODAY_YEAR, $urandom_range(1900, 2099));
                    write_reg(bncd_pkg::REG_TODAY_MONTH, $urandom_range(1, 12));
                    write_reg(bncd_pkg::REG_TODAY_DAY, $urandom_range(1, 31));
                end
            endcase

            @(negedge i_clk);
            pushed = 0;
            if (phase == 0) begin
                // Female, 1954, remainder of ten with a zero check digit.
                make_number(54, 51, 15, 1'b1);
                push_string(pushed);
                // Lone final characters at both ends of the code range.
                str_chars[0] = 8'h00;
                str_len = 1;
                push_string(pushed);
                str_chars[0] = 8'hFF;
                push_string(pushed);
                // Twelve digits: the count saturates and the number fails.
                make_number(53, 12, 31, 1'b0);
                str_chars[10] = 8'd57;
                str_chars[11] = 8'd48;
                str_len = 12;
                push_string(pushed);
            end
            while (pushed < CHARS_PER_PHASE) begin
                gen_string();
                push_string(pushed);
            end
            // The sender holds off here until every result has come back.
            drain();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/bncd_pkg.sv
rtl/birth_number_check_decode.sv
tb/tb_birth_number_check_decode.sv
